>>> rtl/lidt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidt_pkg
// Shared constants, types and helpers for the leg torque pipeline.
// ----------------------------------------------------------------------------
package lidt_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int SINE_STEPS = 16;
    localparam int ATAN_N     = 24;
    localparam int CORDIC_N   = (SINE_STEPS < ATAN_N) ? SINE_STEPS : ATAN_N;

    localparam logic [33:0] PI_Q30     = 34'd3373259426;
    localparam logic [33:0] PI_FIX     = PI_Q30 >> (30 - FRAC_BITS);
    localparam logic [34:0] TWO_PI_FIX = {PI_FIX, 1'b0};
    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

    // register indexes
    localparam logic [2:0] REG_PGAIN  = 3'd0;
    localparam logic [2:0] REG_VGAIN  = 3'd1;
    localparam logic [2:0] REG_TLIM   = 3'd2;
    localparam logic [2:0] REG_MASS   = 3'd3;
    localparam logic [2:0] REG_GRAV   = 3'd4;
    localparam logic [2:0] REG_LINK   = 3'd5;

    typedef struct packed {
        logic [30:0]        position_gain;
        logic [30:0]        velocity_gain;
        logic [30:0]        torque_limit;
        logic [30:0]        lumped_mass;
        logic signed [31:0] gravity_accel;
        logic [30:0]        link_length;
    } cfg_t;

    function automatic logic signed [33:0] atan_q30(input int i);
        logic signed [33:0] t [ATAN_N];
        t = '{34'sd843314857, 34'sd497837830, 34'sd263043837, 34'sd133525159,
              34'sd67021687, 34'sd33543515, 34'sd16775850, 34'sd8388438,
              34'sd4194283, 34'sd2097149, 34'sd1048576, 34'sd524288,
              34'sd262144, 34'sd131072, 34'sd65536, 34'sd32768,
              34'sd16384, 34'sd8192, 34'sd4096, 34'sd2048,
              34'sd1024, 34'sd512, 34'sd256, 34'sd128};
        return t[i];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)       return 32'sh7fffffff;
        else if (v < -66'sd2147483648) return 32'sh80000000;
        else                           return v[31:0];
    endfunction

endpackage

>>> rtl/lidt_sine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidt_sine
// Pipelined sine: range fold then one CORDIC rotation per stage.
// ----------------------------------------------------------------------------
module lidt_sine (
    input  logic                     aclk,
    input  logic                     en,
    input  logic signed [19:0]       angle,
    output logic signed [31:0]       sine
);
    import lidt_pkg::*;

    localparam int NS = CORDIC_N + 1;

    logic signed [33:0] x_reg [NS];
    logic signed [33:0] y_reg [NS];
    logic signed [33:0] z_reg [NS];
    logic signed [33:0] z_next;
    logic signed [35:0] r;
    logic signed [35:0] pi_s;

    // fold into [-pi/2, pi/2]; input is within +/- 8, so a 2pi wrap precedes the pi wrap
    always_comb begin
        pi_s = $signed({2'b00, PI_FIX});
        r = 36'(angle);
        if (r >= $signed({1'b0, TWO_PI_FIX}))       r = r - $signed({1'b0, TWO_PI_FIX});
        if (r <= -$signed({1'b0, TWO_PI_FIX}))      r = r + $signed({1'b0, TWO_PI_FIX});
        if (r > pi_s)                               r = r - $signed({1'b0, TWO_PI_FIX});
        if (r < -pi_s)                              r = r + $signed({1'b0, TWO_PI_FIX});
        if ((r <<< 1) > pi_s)                       r = pi_s - r;
        if ((r <<< 1) < -pi_s)                      r = -pi_s - r;
        z_next = 34'(r <<< (30 - FRAC_BITS));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0] <= CORDIC_X0;
            y_reg[0] <= '0;
            z_reg[0] <= z_next;
        end
    end

    for (genvar i = 0; i < CORDIC_N; i++) begin : g_rot
        always_ff @(posedge aclk) begin
            if (en) begin
                if (z_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_q30(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_q30(i);
                end
            end
        end
    end

    assign sine = 32'(y_reg[NS-1] >>> (30 - FRAC_BITS));
endmodule

>>> rtl/lidt_force.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidt_force
// Pipelined PD plus feedforward force, padded to the sine latency.
// ----------------------------------------------------------------------------
module lidt_force (
    input  logic                 aclk,
    input  logic                 en,
    input  lidt_pkg::cfg_t       cfg,
    input  logic signed [31:0]   dh,
    input  logic signed [31:0]   dv,
    input  logic signed [31:0]   da,
    input  logic signed [31:0]   mh,
    input  logic signed [31:0]   mv,
    output logic signed [31:0]   force_out
);
    import lidt_pkg::*;

    localparam int PAD = CORDIC_N + 1 - 4;

    logic signed [31:0] perr_reg, verr_reg, da1_reg;
    logic signed [31:0] pt_reg, vt_reg, da2_reg;
    logic signed [31:0] sum_reg;
    logic signed [31:0] f_reg [PAD+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            perr_reg <= sat32(66'(dh) - 66'(mh));
            verr_reg <= sat32(66'(dv) - 66'(mv));
            da1_reg  <= da;
            pt_reg   <= sat32(66'((64'($signed({1'b0, cfg.position_gain}))
                              * 64'(perr_reg)) >>> FRAC_BITS));
            vt_reg   <= sat32(66'((64'($signed({1'b0, cfg.velocity_gain}))
                              * 64'(verr_reg)) >>> FRAC_BITS));
            da2_reg  <= da1_reg;
            sum_reg  <= sat32(66'(da2_reg) + 66'(pt_reg) + 66'(vt_reg)
                              - 66'(cfg.gravity_accel));
            f_reg[0] <= sat32(66'((64'($signed({1'b0, cfg.lumped_mass}))
                              * 64'(sum_reg)) >>> FRAC_BITS));
        end
    end

    for (genvar i = 0; i < PAD; i++) begin : g_pad
        always_ff @(posedge aclk) begin
            if (en) f_reg[i+1] <= f_reg[i];
        end
    end

    assign force_out = f_reg[PAD];
endmodule

>>> rtl/leg_inverse_dynamics_torque.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leg_inverse_dynamics_torque
// PD plus feedforward vertical force mapped to hip and knee torques.
// ----------------------------------------------------------------------------
// Path: the input beat passes the range fold and the CORDIC stage chain, then
// the link product, Jacobian and clamp registers, to the result.
// Throughput: one beat per cycle; the whole pipe advances when the output
// register is free or being taken.
// Reset: aresetn clears the valid bits and loads the register defaults.
module leg_inverse_dynamics_torque (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // desired_height, desired_speed, desired_accel, measured_height,
    // measured_speed, hip_angle[18:0], knee_angle[18:0], zero pad
    input  logic [199:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // vertical_force, hip_torque, knee_torque, hip_clamped, knee_clamped, pad
    output logic [103:0] m_tdata
);
    import lidt_pkg::*;

    localparam int DEPTH = CORDIC_N + 4;

    cfg_t cfg_reg;
    logic en;
    logic [DEPTH-1:0] vld_reg;
    logic signed [31:0] force_w, s1, s12;
    logic signed [19:0] a1, a12;
    logic signed [31:0] f1_reg, f2_reg, j1_reg, j2_reg;
    logic signed [65:0] t1_reg, t12_reg;
    logic signed [31:0] th, tk, lim;
    logic signed [31:0] th_reg, tk_reg, vf_reg;
    logic thc_reg, tkc_reg;
    logic signed [63:0] ph, pk;

    assign en = ~m_tvalid | m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.position_gain <= 31'd3276800;
            cfg_reg.velocity_gain <= 31'd163840;
            cfg_reg.torque_limit  <= 31'd655360;
            cfg_reg.lumped_mass   <= 31'd131662;
            cfg_reg.gravity_accel <= -32'sd642908;
            cfg_reg.link_length   <= 31'd15073;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_PGAIN: cfg_reg.position_gain <= cfg_data[30:0];
                REG_VGAIN: cfg_reg.velocity_gain <= cfg_data[30:0];
                REG_TLIM:  cfg_reg.torque_limit  <= cfg_data[30:0];
                REG_MASS:  cfg_reg.lumped_mass   <= cfg_data[30:0];
                REG_GRAV:  cfg_reg.gravity_accel <= cfg_data;
                REG_LINK:  cfg_reg.link_length   <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (en)  vld_reg <= {vld_reg[DEPTH-2:0], s_tvalid};
    end
    assign m_tvalid = vld_reg[DEPTH-1];

    assign a1  = 20'($signed(s_tdata[178:160]));
    assign a12 = 20'($signed(s_tdata[178:160])) + 20'($signed(s_tdata[197:179]));

    lidt_sine u_sin1 (.aclk(aclk), .en(en), .angle(a1), .sine(s1));
    lidt_sine u_sin12 (.aclk(aclk), .en(en), .angle(a12), .sine(s12));

    lidt_force u_force (
        .aclk(aclk), .en(en), .cfg(cfg_reg),
        .dh(s_tdata[31:0]), .dv(s_tdata[63:32]), .da(s_tdata[95:64]),
        .mh(s_tdata[127:96]), .mv(s_tdata[159:128]), .force_out(force_w)
    );

    // Jacobian, torque product, clamp
    assign ph  = j1_reg * f2_reg;
    assign pk  = j2_reg * f2_reg;
    assign lim = $signed({1'b0, cfg_reg.torque_limit});
    assign th  = sat32(66'(ph >>> FRAC_BITS));
    assign tk  = sat32(66'(pk >>> FRAC_BITS));

    always_ff @(posedge aclk) begin
        if (en) begin
            t1_reg  <= 66'((64'($signed({1'b0, cfg_reg.link_length})) * 64'(s1))
                           >>> FRAC_BITS);
            t12_reg <= 66'((64'($signed({1'b0, cfg_reg.link_length})) * 64'(s12))
                           >>> FRAC_BITS);
            f1_reg  <= force_w;
            j1_reg  <= sat32(-t1_reg - t12_reg);
            j2_reg  <= sat32(-t12_reg);
            f2_reg  <= f1_reg;
            vf_reg  <= f2_reg;
            thc_reg <= (th > lim) || (th < -lim);
            tkc_reg <= (tk > lim) || (tk < -lim);
            th_reg  <= (th > lim) ? lim : ((th < -lim) ? -lim : th);
            tk_reg  <= (tk > lim) ? lim : ((tk < -lim) ? -lim : tk);
        end
    end

    assign m_tdata = {6'd0, tkc_reg, thc_reg, tk_reg, th_reg, vf_reg};

    a_clamp_hip: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !thc_reg |-> (th_reg <= $signed({1'b0, cfg_reg.torque_limit})))
        else $error("hip torque above limit unflagged");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result lost under stall");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("stall without pending result");
endmodule
